@@ src/qte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants of the quaternion to Euler converter
// Holds the product-sum record passed from the front end to the back end,
// the fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CompW  = 16;   // quaternion component width
  localparam int SumW   = 34;   // product sums, 1.0 = 2^30
  localparam int RootW  = 31;   // square root of a value below 2^61
  localparam int RemW   = 61;   // 2^60 - s^2
  localparam int UnitW  = 16;   // angle in 1/128 degree
  localparam int PitchW = 15;
  localparam int AngW   = 26;   // angle in degrees * 2^16
  localparam int CordW  = 37;   // CORDIC vector components
  localparam int CordSteps = 20;
  localparam int SqrtSteps = 31;
  localparam int CordLat = CordSteps + 2;

  localparam logic signed [SumW-1:0]   OneQ30   = SumW'(64'sd1073741824);
  localparam logic signed [AngW-1:0]   Deg180   = AngW'(32'sd11796480);
  localparam logic signed [PitchW-1:0] PitchMax = PitchW'(16'sd11520);

  typedef struct packed {
    logic signed [SumW-1:0] sinr;
    logic signed [SumW-1:0] cosr;
    logic signed [SumW-1:0] sinp;
    logic signed [SumW-1:0] siny;
    logic signed [SumW-1:0] cosy;
  } qte_sums_t;

  // round(atan(2^-i) in degrees * 2^16)
  function automatic logic [AngW-1:0] atan_tab(input int i);
    logic [AngW-1:0] r;
    unique case (i)
      0:  r = AngW'(2949120);
      1:  r = AngW'(1740967);
      2:  r = AngW'(919879);
      3:  r = AngW'(466945);
      4:  r = AngW'(234379);
      5:  r = AngW'(117304);
      6:  r = AngW'(58666);
      7:  r = AngW'(29335);
      8:  r = AngW'(14668);
      9:  r = AngW'(7334);
      10: r = AngW'(3667);
      11: r = AngW'(1833);
      12: r = AngW'(917);
      13: r = AngW'(458);
      14: r = AngW'(229);
      15: r = AngW'(115);
      16: r = AngW'(57);
      17: r = AngW'(29);
      18: r = AngW'(14);
      19: r = AngW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/qte_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_fifo: short queue between front end and back end
// Register-based FIFO with a fill count; no push is issued while full.
// ----------------------------------------------------------------------------
module qte_fifo #(
  parameter int Depth = 4,
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wptr, rptr;
  logic [CntW-1:0]  count;
  logic             do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("queue count above depth");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");
  a_push_moves: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");

endmodule

@@ src/qte_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_front: input stage that forms the quaternion product sums
// One stage of 16x16 products, one stage of sums; stalls only when the
// queue behind it is full.
// ----------------------------------------------------------------------------
module qte_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,
  input  logic              q_full,
  output logic              sums_valid,
  output qte_pkg::qte_sums_t sums
);
  import qte_pkg::*;

  logic signed [CompW-1:0] qx, qy, qz, qw;
  logic signed [2*CompW-1:0] p_wx, p_yz, p_wy, p_zx, p_wz, p_xy, p_xx, p_yy, p_zz;
  logic f1_valid, f2_valid, fadv;

  assign qx = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qz = s_tdata[47:32];
  assign qw = s_tdata[63:48];

  assign fadv       = !(f2_valid && q_full);
  assign s_tready   = fadv;
  assign sums_valid = f2_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (fadv) begin
      f1_valid <= s_tvalid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fadv && s_tvalid) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
    end
  end

  always_ff @(posedge clk) begin
    if (fadv && f1_valid) begin
      sums.sinr <= (SumW'(p_wx) + SumW'(p_yz)) <<< 1;
      sums.sinp <= (SumW'(p_wy) - SumW'(p_zx)) <<< 1;
      sums.siny <= (SumW'(p_wz) + SumW'(p_xy)) <<< 1;
      sums.cosr <= OneQ30 - ((SumW'(p_xx) + SumW'(p_yy)) <<< 1);
      sums.cosy <= OneQ30 - ((SumW'(p_yy) + SumW'(p_zz)) <<< 1);
    end
  end

endmodule

@@ src/qte_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(v)); a side payload travels along.
// ----------------------------------------------------------------------------
module qte_sqrt #(
  parameter int SideW = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [qte_pkg::RemW-1:0] v_in,
  input  logic [SideW-1:0]         side_in,
  output logic [qte_pkg::RootW-1:0] root,
  output logic [SideW-1:0]         side_out
);
  import qte_pkg::*;

  localparam int WorkW = RemW + 1;

  logic [WorkW-1:0] v_r   [SqrtSteps+1];
  logic [WorkW-1:0] res_r [SqrtSteps+1];
  logic [SideW-1:0] sd_r  [SqrtSteps+1];

  assign v_r[0]   = WorkW'(v_in);
  assign res_r[0] = '0;
  assign sd_r[0]  = side_in;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [WorkW-1:0] Bit = WorkW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [WorkW-1:0] trial;
    assign trial = res_r[k] + Bit;
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[k+1] <= sd_r[k];
        if (v_r[k] >= trial) begin
          v_r[k+1]   <= v_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + Bit;
        end else begin
          v_r[k+1]   <= v_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  assign root     = res_r[SqrtSteps][RootW-1:0];
  assign side_out = sd_r[SqrtSteps];

endmodule

@@ src/qte_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC for atan2
// Quadrant fold stage, 20 rotation stages, then clamp and rounding to
// 1/128 degree into the output register; all stages advance on enable.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qte_pkg::SumW-1:0] y_in,
  input  logic signed [qte_pkg::SumW-1:0] x_in,
  output logic signed [qte_pkg::UnitW-1:0] units
);
  import qte_pkg::*;

  logic signed [CordW-1:0] x_r [CordSteps+1];
  logic signed [CordW-1:0] y_r [CordSteps+1];
  logic signed [AngW-1:0]  a_r [CordSteps+1];
  logic                    h_r [CordSteps+1];
  logic signed [CordW-1:0] xe, ye;
  logic signed [AngW-1:0]  a_cl, a_rnd;

  assign xe = CordW'(x_in);
  assign ye = CordW'(y_in);

  // On the x axis the angle is final; otherwise fold the left half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in == '0) begin
        h_r[0] <= 1'b1;
        a_r[0] <= (x_in < 0) ? Deg180 : '0;
        x_r[0] <= xe;
        y_r[0] <= ye;
      end else if (x_in < 0) begin
        h_r[0] <= 1'b0;
        a_r[0] <= (y_in >= 0) ? Deg180 : -Deg180;
        x_r[0] <= -xe;
        y_r[0] <= -ye;
      end else begin
        h_r[0] <= 1'b0;
        a_r[0] <= '0;
        x_r[0] <= xe;
        y_r[0] <= ye;
      end
    end
  end

  for (genvar i = 0; i < CordSteps; i++) begin : g_rot
    localparam logic signed [AngW-1:0] Tab = atan_tab(i);
    logic signed [CordW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        h_r[i+1] <= h_r[i];
        if (h_r[i]) begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          a_r[i+1] <= a_r[i];
        end else if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          a_r[i+1] <= a_r[i] + Tab;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          a_r[i+1] <= a_r[i] - Tab;
        end
      end
    end
  end

  always_comb begin
    a_cl = a_r[CordSteps];
    if (a_cl > Deg180) begin
      a_cl = Deg180;
    end else if (a_cl < -Deg180) begin
      a_cl = -Deg180;
    end
    a_rnd = a_cl + AngW'(256);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      units <= UnitW'(a_rnd >>> 9);
    end
  end

endmodule

@@ src/quat_to_euler_angles_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_to_euler_angles_top: quaternion to ZYX Euler angles converter
// Front end forms product sums, a short queue decouples it from the back
// end, which runs a square root and three CORDIC arctangent pipelines.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the s_ channel is one quaternion (x, y, z, w), signed
// Q1.15. Each output item on the m_ channel carries pitch, negated yaw and
// negated roll in units of 1/128 degree. Every input item gives exactly one
// output item, in order. The block keeps no state between items.
// Throughput is one item per cycle, sustained while the receiver takes items.
// From input acceptance to output valid, when nothing stalls, the item passes
// 59 registers, the first loaded at the accepting edge: 2 front stages, the
// queue register, 2 back stages for the pitch term square, 31 square root
// stages and 22 CORDIC stages, then the output register. The square root
// pipeline holds most of those registers.
// When m_tvalid is high and the receiver holds m_tready low, the whole back
// end freezes; the front end keeps accepting until the queue of QueueDepth
// items fills, and then s_tready drops. Reset (rst, synchronous) empties all
// valid stages and the queue; no output item is shown until new input arrives.
// ----------------------------------------------------------------------------
module quat_to_euler_angles_top #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // pitch_deg, yaw_deg, roll_deg, 1 pad bit
);
  import qte_pkg::*;

  localparam int SumsW = $bits(qte_sums_t);
  localparam int SideW = SumsW + 1;

  // Front end and queue.
  logic       sums_valid, q_full, q_empty, pop, adv;
  qte_sums_t  f_sums, q_sums;
  logic [SumsW-1:0] q_rdata;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .sums_valid(sums_valid),
    .sums      (f_sums)
  );

  qte_fifo #(.Depth(QueueDepth), .Width(SumsW)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (sums_valid),
    .wdata(f_sums),
    .pop  (pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign q_sums = qte_sums_t'(q_rdata);

  // The back end advances as a whole whenever the output register is empty or its item is taken.
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_empty;

  // Back stage 0: square of the pitch term and the saturation check.
  logic                       b0_valid, b0_sat, b1_valid, b1_sat;
  qte_sums_t                  b0_sums, b1_sums;
  logic signed [2*RootW-1:0]  b0_sq;
  logic [RemW-1:0]            b1_rem;
  logic signed [RootW-1:0]    sinp_n;

  assign sinp_n = RootW'(q_sums.sinp);

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
      b1_valid <= 1'b0;
    end else if (adv) begin
      b0_valid <= pop;
      b1_valid <= b0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_sums <= q_sums;
      b0_sat  <= (q_sums.sinp >= OneQ30) || (q_sums.sinp <= -OneQ30);
      b0_sq   <= sinp_n * sinp_n;
      b1_sums <= b0_sums;
      b1_sat  <= b0_sat;
      b1_rem  <= b0_sat ? '0 : (RemW'(1) << 60) - RemW'(b0_sq);
    end
  end

  // Square root of 1 - s^2 gives the cosine leg for asin.
  logic [RootW-1:0] root;
  logic [SideW-1:0] sq_side;
  qte_sums_t        s_sums;
  logic             s_valid, s_sat;
  logic [SqrtSteps-1:0] s_vpipe;

  qte_sqrt #(.SideW(SideW)) u_sqrt (
    .clk     (clk),
    .en      (adv),
    .v_in    (b1_rem),
    .side_in ({b1_sat, b1_sums}),
    .root    (root),
    .side_out(sq_side)
  );

  assign {s_sat, s_sums} = sq_side;

  // Valid flags of the square root stages, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vpipe <= '0;
    end else if (adv) begin
      s_vpipe <= {s_vpipe[SqrtSteps-2:0], b1_valid};
    end
  end

  assign s_valid = s_vpipe[SqrtSteps-1];

  // Three CORDIC pipelines in lockstep.
  logic signed [UnitW-1:0] pitch_u, yaw_u, roll_u;

  qte_cordic u_pitch (
    .clk  (clk),
    .en   (adv),
    .y_in (s_sums.sinp),
    .x_in (SumW'(root)),
    .units(pitch_u)
  );

  qte_cordic u_yaw (
    .clk  (clk),
    .en   (adv),
    .y_in (s_sums.siny),
    .x_in (s_sums.cosy),
    .units(yaw_u)
  );

  qte_cordic u_roll (
    .clk  (clk),
    .en   (adv),
    .y_in (s_sums.sinr),
    .x_in (s_sums.cosr),
    .units(roll_u)
  );

  // Valid, saturation and pitch sign ride alongside the CORDIC stages.
  logic [CordLat-1:0] c_valid, c_sat, c_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else if (adv) begin
      c_valid <= {c_valid[CordLat-2:0], s_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sat <= {c_sat[CordLat-2:0], s_sat};
      c_neg <= {c_neg[CordLat-2:0], s_sums.sinp[SumW-1]};
    end
  end

  // Output register: pitch clamp and sign flip of yaw and roll.
  logic signed [PitchW-1:0] pitch_sel;
  logic signed [PitchW-1:0] pitch_q;
  logic signed [UnitW-1:0]  yaw_q, roll_q;

  always_comb begin
    if (c_sat[CordLat-1]) begin
      pitch_sel = c_neg[CordLat-1] ? -PitchMax : PitchMax;
    end else if (pitch_u > UnitW'(PitchMax)) begin
      pitch_sel = PitchMax;
    end else if (pitch_u < -UnitW'(PitchMax)) begin
      pitch_sel = -PitchMax;
    end else begin
      pitch_sel = PitchW'(pitch_u);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_valid[CordLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_q <= pitch_sel;
      yaw_q   <= -yaw_u;
      roll_q  <= -roll_u;
    end
  end

  assign m_tdata = {1'b0, roll_q, yaw_q, pitch_q};

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_q <= PitchMax) && (pitch_q >= -PitchMax))
    else $error("pitch out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (yaw_q <= 16'sd23040) && (yaw_q >= -16'sd23040))
    else $error("yaw out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (roll_q <= 16'sd23040) && (roll_q >= -16'sd23040))
    else $error("roll out of range");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!adv && !q_empty) |=> !$past(pop))
    else $error("queue popped while back end stalled");

endmodule
